@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ntsp_pkg.sv @@
// ----------------------------------------------------------------------------
// ntsp_pkg
// Types and constants of the normal and tangent snorm packer.
// ----------------------------------------------------------------------------
package ntsp_pkg;

    // Width of one input component.
    localparam int COMPONENT_BITS = 16;

    // Components per vector, vectors per item, lanes in total.
    localparam int VEC_LEN = 3;
    localparam int VEC_NUM = 2;
    localparam int LANES   = VEC_LEN * VEC_NUM;

    // Output field layout.
    localparam int FIELD_W  = 10;
    localparam int PACKED_W = FIELD_W * VEC_LEN;

    // Snorm scale and its doubled form used in the numerator.
    localparam int SCALE     = 511;
    localparam int SCALE_X2  = 2 * SCALE;

    // Magnitude holds up to 2^(COMPONENT_BITS-1).
    localparam int MAG_W = COMPONENT_BITS;
    // Divisor is twice the largest magnitude.
    localparam int DEN_W = COMPONENT_BITS + 1;
    // Numerator 1022*mag + m stays below 2^(COMPONENT_BITS+9).
    localparam int NUM_W = COMPONENT_BITS + 9;

    // Quotient bits, split evenly over the divider stages.
    localparam int Q_W             = FIELD_W - 1;
    localparam int DIV_STAGES      = 3;
    localparam int STEPS_PER_STAGE = Q_W / DIV_STAGES;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] normal_x;
        logic signed [COMPONENT_BITS-1:0] normal_y;
        logic signed [COMPONENT_BITS-1:0] normal_z;
        logic signed [COMPONENT_BITS-1:0] tangent_x;
        logic signed [COMPONENT_BITS-1:0] tangent_y;
        logic signed [COMPONENT_BITS-1:0] tangent_z;
    } in_item_t;

    typedef struct packed {
        logic [PACKED_W-1:0] packed_normal;
        logic [PACKED_W-1:0] packed_tangent;
    } out_item_t;

endpackage

@@ design/normal_tangent_snorm_packer.sv @@
// ----------------------------------------------------------------------------
// normal_tangent_snorm_packer
// Scales each vector by its largest absolute component to +-511 with
// half-away rounding and packs x, y, z into 10-bit two's complement fields.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake                   | payload
//  ---------+-----------+-----------------------------+------------------------
//  item     | in        | item_valid / item_stall     | in_item_t   (six comps)
//  result   | out       | result_valid / result_stall | out_item_t  (two words)
//
//  One item per cycle sustained while result_stall is low; an accepted item
//  reaches result_valid through six register stages: magnitude/max,
//  numerator, three divider stages of three quotient bits each (set by the
//  restoring compare-subtract chain), pack.
//  Reset clears the stage valid bits only; the pipeline starts empty.
//  A stall holds only the stages that are full behind it; empty stages
//  keep filling, so nothing is lost or repeated.
//
`include "assert_macros.svh"

module normal_tangent_snorm_packer
    import ntsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    logic                a_valid_reg;
    logic [MAG_W-1:0]    a_mag_reg  [LANES];
    logic                a_neg_reg  [LANES];
    logic [MAG_W-1:0]    a_max_reg  [VEC_NUM];
    logic [MAG_W-1:0]    a_mag_next [LANES];
    logic                a_neg_next [LANES];
    logic [MAG_W-1:0]    a_max_next [VEC_NUM];

    // Divider pipeline: index 0 holds the loaded numerator, the rest the
    // output of each divider stage.
    logic [DIV_STAGES:0] p_valid_reg;
    logic [NUM_W-1:0]    p_rem_reg  [DIV_STAGES+1][LANES];
    logic [Q_W-1:0]      p_q_reg    [DIV_STAGES+1][LANES];
    logic                p_neg_reg  [DIV_STAGES+1][LANES];
    logic [DEN_W-1:0]    p_den_reg  [DIV_STAGES+1][VEC_NUM];
    logic                p_zero_reg [DIV_STAGES+1][VEC_NUM];
    logic [NUM_W-1:0]    p_rem_next [DIV_STAGES+1][LANES];
    logic [Q_W-1:0]      p_q_next   [DIV_STAGES+1][LANES];

    logic                result_valid_reg;
    out_item_t           result_reg;
    out_item_t           result_next;

    // Stage enables
    logic                a_en;
    logic [DIV_STAGES:0] p_en;
    logic                out_en;

    logic [COMPONENT_BITS-1:0] comp [LANES];

    // ------------------------------------------------------------------
    // Advance a stage when it is empty or the stage after it advances
    // ------------------------------------------------------------------
    always_comb
    begin
        out_en = !result_valid_reg || !result_stall;
        p_en[DIV_STAGES] = !p_valid_reg[DIV_STAGES] || out_en;
        for (int s = DIV_STAGES - 1; s >= 0; s--)
        begin
            p_en[s] = !p_valid_reg[s] || p_en[s+1];
        end
        a_en = !a_valid_reg || p_en[0];
    end

    assign item_stall   = !a_en;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // Stage A: split sign and magnitude, find the largest magnitude
    // ------------------------------------------------------------------
    assign comp[0] = item.normal_x;
    assign comp[1] = item.normal_y;
    assign comp[2] = item.normal_z;
    assign comp[3] = item.tangent_x;
    assign comp[4] = item.tangent_y;
    assign comp[5] = item.tangent_z;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            a_neg_next[l] = comp[l][COMPONENT_BITS-1];
            a_mag_next[l] = a_neg_next[l] ? (~comp[l] + MAG_W'(1)) : comp[l];
        end
        for (int v = 0; v < VEC_NUM; v++)
        begin
            a_max_next[v] = a_mag_next[v*VEC_LEN];
            for (int c = 1; c < VEC_LEN; c++)
            begin
                if (a_mag_next[v*VEC_LEN + c] > a_max_next[v])
                begin
                    a_max_next[v] = a_mag_next[v*VEC_LEN + c];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Numerator load and restoring division steps
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic [NUM_W-1:0] trial;
        int               k;

        // Load: numerator 1022*mag + m, quotient cleared
        for (int v = 0; v < VEC_NUM; v++)
        begin
            for (int c = 0; c < VEC_LEN; c++)
            begin
                p_rem_next[0][v*VEC_LEN + c] =
                    NUM_W'(a_mag_reg[v*VEC_LEN + c]) * NUM_W'(SCALE_X2)
                    + NUM_W'(a_max_reg[v]);
                p_q_next[0][v*VEC_LEN + c] = '0;
            end
        end

        // Each divider stage resolves STEPS_PER_STAGE quotient bits, msb first
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            for (int v = 0; v < VEC_NUM; v++)
            begin
                for (int c = 0; c < VEC_LEN; c++)
                begin
                    rem = p_rem_reg[s-1][v*VEC_LEN + c];
                    q   = p_q_reg[s-1][v*VEC_LEN + c];
                    for (int j = 0; j < STEPS_PER_STAGE; j++)
                    begin
                        k     = Q_W - 1 - (s - 1) * STEPS_PER_STAGE - j;
                        trial = NUM_W'(p_den_reg[s-1][v]) << k;
                        if (rem >= trial)
                        begin
                            rem = rem - trial;
                            q   = q | (Q_W'(1) << k);
                        end
                    end
                    p_rem_next[s][v*VEC_LEN + c] = rem;
                    p_q_next[s][v*VEC_LEN + c]   = q;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Pack: apply sign, drop all-zero vectors
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [FIELD_W-1:0]  code;
        logic [PACKED_W-1:0] word [VEC_NUM];
        for (int v = 0; v < VEC_NUM; v++)
        begin
            word[v] = '0;
            for (int c = 0; c < VEC_LEN; c++)
            begin
                code = {1'b0, p_q_reg[DIV_STAGES][v*VEC_LEN + c]};
                if (p_neg_reg[DIV_STAGES][v*VEC_LEN + c])
                begin
                    code = ~code + FIELD_W'(1);
                end
                if (p_zero_reg[DIV_STAGES][v])
                begin
                    code = '0;
                end
                word[v][c*FIELD_W +: FIELD_W] = code;
            end
        end
        result_next.packed_normal  = word[0];
        result_next.packed_tangent = word[1];
    end

    // ------------------------------------------------------------------
    // Valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg      <= 1'b0;
            p_valid_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= item_valid;
            end
            if (p_en[0])
            begin
                p_valid_reg[0] <= a_valid_reg;
            end
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                if (p_en[s])
                begin
                    p_valid_reg[s] <= p_valid_reg[s-1];
                end
            end
            if (out_en)
            begin
                result_valid_reg <= p_valid_reg[DIV_STAGES];
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: load on enable, hold otherwise
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_mag_reg <= a_mag_next;
            a_neg_reg <= a_neg_next;
            a_max_reg <= a_max_next;
        end
        if (p_en[0])
        begin
            p_rem_reg[0] <= p_rem_next[0];
            p_q_reg[0]   <= p_q_next[0];
            p_neg_reg[0] <= a_neg_reg;
            for (int v = 0; v < VEC_NUM; v++)
            begin
                p_den_reg[0][v]  <= {a_max_reg[v], 1'b0};
                p_zero_reg[0][v] <= (a_max_reg[v] == '0);
            end
        end
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            if (p_en[s])
            begin
                p_rem_reg[s]  <= p_rem_next[s];
                p_q_reg[s]    <= p_q_next[s];
                p_neg_reg[s]  <= p_neg_reg[s-1];
                p_den_reg[s]  <= p_den_reg[s-1];
                p_zero_reg[s] <= p_zero_reg[s-1];
            end
        end
        if (out_en)
        begin
            result_reg <= result_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_fills, item_valid && !item_stall, a_valid_reg,
        "accepted item did not reach the first stage")
    `ASSERT_NEXT(div_hold_on_stall, p_valid_reg[DIV_STAGES] && !p_en[DIV_STAGES],
        p_valid_reg[DIV_STAGES], "item dropped from last divider stage while stalled")
    `ASSERT_ALWAYS(div_rem_bound,
        !p_valid_reg[DIV_STAGES] || p_zero_reg[DIV_STAGES][0] ||
        (p_rem_reg[DIV_STAGES][0] < NUM_W'(p_den_reg[DIV_STAGES][0])),
        "divider remainder not below divisor after last step")
    `ASSERT_ALWAYS(field_not_min,
        !result_valid_reg ||
        ((result_reg.packed_normal[FIELD_W-1:0] != 10'h200) &&
         (result_reg.packed_normal[2*FIELD_W-1:FIELD_W] != 10'h200) &&
         (result_reg.packed_normal[3*FIELD_W-1:2*FIELD_W] != 10'h200) &&
         (result_reg.packed_tangent[FIELD_W-1:0] != 10'h200) &&
         (result_reg.packed_tangent[2*FIELD_W-1:FIELD_W] != 10'h200) &&
         (result_reg.packed_tangent[3*FIELD_W-1:2*FIELD_W] != 10'h200)),
        "packed field outside the snorm range")

endmodule
